>>> sv/sof_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sof_pkg
// Shared types and constants of the sprite outline filter.
// ----------------------------------------------------------------------------
package sof_pkg;

    localparam int DEFAULT_MAX_WIDTH = 256;
    localparam int HEIGHT_LIMIT      = 4096;

    localparam int RGBA_BITS  = 32;
    localparam int IMG_W_BITS = 9;
    localparam int IMG_H_BITS = 13;
    localparam int ROW_BITS   = 13;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [IMG_W_BITS-1:0] IMAGE_WIDTH_RESET   = 9'd16;
    localparam logic [IMG_H_BITS-1:0] IMAGE_HEIGHT_RESET  = 13'd16;
    localparam logic [RGBA_BITS-1:0]  OUTLINE_COLOR_RESET = 32'hFFFF_FFFF;

    localparam logic [8:0] MASK_LEFT   = 9'h007;
    localparam logic [8:0] MASK_RIGHT  = 9'h1C0;
    localparam logic [8:0] MASK_TOP    = 9'h049;
    localparam logic [8:0] MASK_BOTTOM = 9'h124;
    localparam logic [8:0] MASK_RING   = 9'h1EF;
    localparam int         CENTRE_BIT  = 4;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_OUTLINE_COLOR = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic above;
        logic cur;
    } opq_t;

    typedef struct packed {
        logic                 frame_end;
        logic [RGBA_BITS-1:0] rgba;
    } result_t;

endpackage
`default_nettype wire

>>> sv/sprite_outline_filter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_outline_filter_unit
// 3x3 alpha dilation outline on a raster RGBA pixel stream.
// Throughput: one request per cycle while s_tready is high; the opacity line
// buffer is a chain of MAX_WIDTH cells that shifts once per request.
// A pixel's result enters the output stage with the request that comes w+1
// requests after it, w being the image width clamped to 1..MAX_WIDTH.
// Reset: counters, window, cell chain and output valid clear at once and the
// registers return to their defaults; the colour memory is not cleared.
// ----------------------------------------------------------------------------
module sprite_outline_filter_unit #(
    parameter int MAX_WIDTH = sof_pkg::DEFAULT_MAX_WIDTH
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // s_tdata: [31:0] pixel_rgba
    input  wire logic [31:0]                      s_tdata,
    // s_tuser: [0] is_padding
    input  wire logic [0:0]                       s_tuser,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // m_tdata: [31:0] out_rgba
    output logic [31:0]                           m_tdata,
    output logic                                  m_tlast,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [sof_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [31:0]                      cfg_data
);
    import sof_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int EW = (WB > IMG_W_BITS) ? WB : IMG_W_BITS;

    logic [IMG_W_BITS-1:0] image_width_reg;
    logic [IMG_H_BITS-1:0] image_height_reg;
    logic [RGBA_BITS-1:0]  outline_color_reg;

    logic [CW-1:0]       col_reg;
    logic [CW-1:0]       col_next;
    logic [ROW_BITS-1:0] row_reg;
    logic [ROW_BITS-1:0] row_next;
    logic [8:0]          win_reg;
    logic [8:0]          win_next;

    logic [EW-1:0]         w_ext;
    logic [EW-1:0]         w_eff;
    logic [CW-1:0]         tap;
    logic [IMG_H_BITS-1:0] h_eff;
    logic [ROW_BITS-1:0]   h_plus1;
    logic [ROW_BITS-1:0]   h_minus1;

    logic [CW-1:0]        col_a;
    logic [ROW_BITS-1:0]  row_a;
    logic [CW-1:0]        col_c;
    logic [ROW_BITS-1:0]  row_c;
    logic [EW-1:0]        col_inc;
    logic [CW-1:0]        col_adv;
    logic [ROW_BITS-1:0]  row_adv;
    logic [RGBA_BITS-1:0] pix;
    logic                 opaque;
    logic [8:0]           win_step;
    logic [8:0]           win_mask;
    logic                 res_valid;
    logic [ROW_BITS-1:0]  orow;
    logic [CW-1:0]        ocol;
    logic                 last;
    logic                 use_outline;

    logic                 accept;
    opq_t                 head;
    opq_t                 entry;
    logic [RGBA_BITS-1:0] centre;
    result_t              res_data;
    result_t              m_data;
    logic                 out_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg   <= IMAGE_WIDTH_RESET;
            image_height_reg  <= IMAGE_HEIGHT_RESET;
            outline_color_reg <= OUTLINE_COLOR_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[IMG_W_BITS-1:0];
                REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data[IMG_H_BITS-1:0];
                REG_OUTLINE_COLOR: outline_color_reg <= cfg_data[RGBA_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_ext = EW'(image_width_reg);
        if (w_ext == '0) begin
            w_eff = EW'(1);
        end else if (w_ext > EW'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        if (image_height_reg == '0) begin
            h_eff = IMG_H_BITS'(1);
        end else if (image_height_reg > IMG_H_BITS'(HEIGHT_LIMIT)) begin
            h_eff = IMG_H_BITS'(HEIGHT_LIMIT);
        end else begin
            h_eff = image_height_reg;
        end
    end

    assign tap      = CW'(w_eff - EW'(1));
    assign h_plus1  = ROW_BITS'(h_eff) + ROW_BITS'(1);
    assign h_minus1 = ROW_BITS'(h_eff) - ROW_BITS'(1);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        if (EW'(col_reg) >= w_eff) begin
            col_a = '0;
            row_a = row_reg + ROW_BITS'(1);
        end else begin
            col_a = col_reg;
            row_a = row_reg;
        end
        if (row_a > h_plus1 || (row_a == h_plus1 && col_a != '0)) begin
            col_c = '0;
            row_c = '0;
        end else begin
            col_c = col_a;
            row_c = row_a;
        end

        if (row_c < ROW_BITS'(h_eff) && !s_tuser[0]) begin
            pix = s_tdata;
        end else begin
            pix = '0;
        end
        opaque   = |pix[31:24];
        win_step = {opaque, head.cur, head.above, win_reg[8:3]};

        res_valid = 1'b0;
        orow      = '0;
        ocol      = '0;
        if (col_c != '0 && row_c != '0) begin
            res_valid = 1'b1;
            orow      = row_c - ROW_BITS'(1);
            ocol      = col_c - CW'(1);
        end else if (col_c == '0 && row_c >= ROW_BITS'(2)) begin
            res_valid = 1'b1;
            orow      = row_c - ROW_BITS'(2);
            ocol      = tap;
        end
        if (orow >= ROW_BITS'(h_eff)) begin
            res_valid = 1'b0;
        end

        col_inc = EW'(col_c) + EW'(1);
        if (col_inc >= w_eff) begin
            col_adv = '0;
            row_adv = row_c + ROW_BITS'(1);
        end else begin
            col_adv = CW'(col_inc);
            row_adv = row_c;
        end

        win_mask = win_step;
        if (ocol == '0) begin
            win_mask = win_mask & ~MASK_LEFT;
        end
        if (ocol == tap) begin
            win_mask = win_mask & ~MASK_RIGHT;
        end
        if (orow == '0) begin
            win_mask = win_mask & ~MASK_TOP;
        end
        if (orow == h_minus1) begin
            win_mask = win_mask & ~MASK_BOTTOM;
        end
        use_outline = !win_mask[CENTRE_BIT] && ((win_mask & MASK_RING) != '0);
        last        = res_valid && (orow == h_minus1) && (ocol == tap);
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        win_next = win_reg;
        if (accept) begin
            win_next = win_step;
            if (last) begin
                col_next = '0;
                row_next = '0;
            end else begin
                col_next = col_adv;
                row_next = row_adv;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            win_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            win_reg <= win_next;
        end
    end

    assign entry.above = head.cur;
    assign entry.cur   = opaque;

    sof_line_chain #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (accept),
        .tap      (tap),
        .entry    (entry),
        .head     (head)
    );

    sof_colour_ram #(
        .DEPTH (MAX_WIDTH)
    ) u_colour (
        .aclk  (aclk),
        .en    (accept),
        .addr  (col_c),
        .wdata (pix),
        .rdata (centre)
    );

    assign res_data.rgba      = use_outline ? outline_color_reg : centre;
    assign res_data.frame_end = last;

    sof_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept && res_valid),
        .push_data (res_data),
        .in_ready  (out_ready),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (m_data)
    );

    assign s_tready = out_ready;
    assign m_tdata  = m_data.rgba;
    assign m_tlast  = m_data.frame_end;

endmodule
`default_nettype wire

>>> sv/sof_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sof_cell
// One column slot of the opacity line buffer: loads a fresh entry or takes
// its neighbor's entry on every shift.
// ----------------------------------------------------------------------------
module sof_cell (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          shift_en,
    input  wire logic          load_sel,
    input  wire sof_pkg::opq_t entry,
    input  wire sof_pkg::opq_t from_next,
    output sof_pkg::opq_t      data
);
    import sof_pkg::*;

    opq_t data_reg;
    opq_t data_next;

    always_comb begin
        data_next = data_reg;
        if (shift_en) begin
            data_next = load_sel ? entry : from_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg <= '0;
        end else begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule
`default_nettype wire

>>> sv/sof_line_chain.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sof_line_chain
// Row of opacity cells: entries enter at the cell of the last column and
// move one cell toward the head per request, giving a delay of one row.
// ----------------------------------------------------------------------------
module sof_line_chain #(
    parameter int MAX_WIDTH = sof_pkg::DEFAULT_MAX_WIDTH
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         shift_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] tap,
    input  wire sof_pkg::opq_t                entry,
    output sof_pkg::opq_t                     head
);
    import sof_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    opq_t cell_data [MAX_WIDTH];

    for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
        opq_t from_next;
        if (i == MAX_WIDTH - 1) begin : g_tail
            assign from_next = '0;
        end else begin : g_body
            assign from_next = cell_data[i+1];
        end

        sof_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift_en  (shift_en),
            .load_sel  (tap == CW'(i)),
            .entry     (entry),
            .from_next (from_next),
            .data      (cell_data[i])
        );
    end

    assign head = cell_data[0];

endmodule
`default_nettype wire

>>> sv/sof_colour_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sof_colour_ram
// Colour line memory: read-before-write at one address, registered read.
// ----------------------------------------------------------------------------
module sof_colour_ram #(
    parameter int DEPTH = sof_pkg::DEFAULT_MAX_WIDTH
) (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic [$clog2(DEPTH)-1:0]      addr,
    input  wire logic [sof_pkg::RGBA_BITS-1:0] wdata,
    output logic      [sof_pkg::RGBA_BITS-1:0] rdata
);
    import sof_pkg::*;

    logic [RGBA_BITS-1:0] mem [DEPTH];
    logic [RGBA_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rdata_reg  <= mem[addr];
            mem[addr]  <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> sv/sof_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sof_out_stage
// Result output register with a skid slot, so the input side never waits
// on the output ready in the same cycle.
// ----------------------------------------------------------------------------
module sof_out_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire sof_pkg::result_t push_data,
    output logic                  in_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output sof_pkg::result_t      m_data
);
    import sof_pkg::*;

    logic    main_valid_reg;
    logic    main_valid_next;
    result_t main_data_reg;
    result_t main_data_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_data_reg;
    result_t skid_data_next;

    always_comb begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!main_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end else if (push) begin
                main_valid_next = 1'b1;
                main_data_next  = push_data;
            end else begin
                main_valid_next = 1'b0;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready = !skid_valid_reg;
    assign m_valid  = main_valid_reg;
    assign m_data   = main_data_reg;

endmodule
`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sprite_outline_filter_unit. A queue of pixel
// requests feeds a clocked driver. Each accepted request runs through a
// local outline predictor whose results are queued and matched in order
// against the output stream. Frames start with directed corner cases and
// extreme sizes, then move to random frames under changing backpressure.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          MAX_COLS     = 256;
    localparam int          MAX_ROWS     = 4096;
    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          SETTLE       = 8;
    localparam int          END_SETTLE   = 32;
    localparam int          LONG_HOLD    = 400;
    localparam int          PHASE_ITEMS  = 170;
    localparam int          MAX_REPORTS  = 20;

    localparam logic [1:0]  REG_SPARE    = 2'd3;

    localparam logic [8:0]  LEFT_COL     = 9'h007;
    localparam logic [8:0]  RIGHT_COL    = 9'h1C0;
    localparam logic [8:0]  TOP_ROW      = 9'h049;
    localparam logic [8:0]  BOTTOM_ROW   = 9'h124;
    localparam logic [8:0]  RING_CELLS   = 9'h1EF;
    localparam logic [8:0]  CENTER_CELL  = 9'h010;

    typedef struct packed {
        logic [31:0] rgba;
        logic        pad;
    } src_item_t;

    typedef struct packed {
        logic [31:0] rgba;
        logic        frame_end;
    } outline_px_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic [31:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [sof_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    src_item_t   pending_src [$];
    outline_px_t expected_px [$];

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic        rx_hold        = 1'b0;
    int          errors         = 0;
    int          cycle_count    = 0;

    logic [8:0]  width_reg   = sof_pkg::IMAGE_WIDTH_RESET;
    logic [12:0] height_reg  = sof_pkg::IMAGE_HEIGHT_RESET;
    logic [31:0] outline_reg = sof_pkg::OUTLINE_COLOR_RESET;

    bit          opq_two_back [MAX_COLS];
    bit          opq_one_back [MAX_COLS];
    logic [31:0] color_line   [MAX_COLS];
    logic [8:0]  alpha_win    = '0;
    logic [31:0] center_rgba  = '0;
    int unsigned col_pos      = 0;
    int unsigned row_pos      = 0;

    sprite_outline_filter_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic int unsigned clamp_width(input logic [8:0] v);
        if (v == 0) return 1;
        if (v > MAX_COLS) return MAX_COLS;
        return v;
    endfunction

    function automatic int unsigned clamp_height(input logic [12:0] v);
        if (v == 0) return 1;
        if (v > MAX_ROWS) return MAX_ROWS;
        return v;
    endfunction

    function automatic void predict_outline(input logic [31:0] rgba, input logic pad);
        int unsigned w, h, r, c, orow, ocol;
        logic [31:0] pix, res;
        logic        opq, hit, last;
        logic [2:0]  newcol;
        logic [8:0]  ring;
        w = clamp_width(width_reg);
        h = clamp_height(height_reg);
        hit = 1'b0;
        orow = 0;
        ocol = 0;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos > h + 1 || (row_pos == h + 1 && col_pos != 0)) begin
            row_pos = 0;
            col_pos = 0;
        end
        r = row_pos;
        c = col_pos;
        pix = (r < h && !pad) ? rgba : 32'h0;
        opq = (pix[31:24] != 8'h00);
        newcol = {opq, opq_one_back[c], opq_two_back[c]};
        opq_two_back[c] = opq_one_back[c];
        opq_one_back[c] = opq;
        alpha_win = {newcol, alpha_win[8:3]};
        res = center_rgba;
        center_rgba = color_line[c];
        color_line[c] = pix;
        if (c >= 1 && r >= 1) begin
            hit = 1'b1;
            orow = r - 1;
            ocol = c - 1;
        end else if (c == 0 && r >= 2) begin
            hit = 1'b1;
            orow = r - 2;
            ocol = w - 1;
        end
        if (hit && orow >= h) hit = 1'b0;
        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
        end
        if (hit) begin
            ring = alpha_win;
            if (ocol == 0) ring &= ~LEFT_COL;
            if (ocol == w - 1) ring &= ~RIGHT_COL;
            if (orow == 0) ring &= ~TOP_ROW;
            if (orow == h - 1) ring &= ~BOTTOM_ROW;
            if ((ring & CENTER_CELL) == 0 && (ring & RING_CELLS) != 0) res = outline_reg;
            last = (orow == h - 1 && ocol == w - 1);
            if (last) begin
                row_pos = 0;
                col_pos = 0;
            end
            expected_px.push_back('{rgba: res, frame_end: last});
        end
    endfunction

    function automatic void push_item(input logic [31:0] rgba, input logic pad);
        pending_src.push_back('{rgba: rgba, pad: pad});
    endfunction

    function automatic logic [31:0] rand_pixel(input int opaque_pct);
        logic [7:0] alpha;
        alpha = ($urandom_range(99) < opaque_pct) ? 8'($urandom_range(1, 255)) : 8'h00;
        return {alpha, 24'($urandom)};
    endfunction

    // queue one whole frame at the current sizes, drain requests included
    function automatic int queue_frame(input int opaque_pct, input int noise_pct);
        int unsigned w, h;
        w = clamp_width(width_reg);
        h = clamp_height(height_reg);
        for (int unsigned i = 0; i < w * h; i++)
            push_item(rand_pixel(opaque_pct), $urandom_range(99) < noise_pct);
        for (int unsigned i = 0; i <= w; i++)
            push_item($urandom, !($urandom_range(99) < noise_pct));
        return w * h + w + 1;
    endfunction

    always @(posedge aclk) begin : drive_pixels
        src_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_outline(s_tdata, s_tuser[0]);
            if (!s_tvalid || s_tready) begin
                if (pending_src.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_src.pop_front();
                    s_tdata  <= nxt.rgba;
                    s_tuser  <= nxt.pad;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : watch_results
        outline_px_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_px.size() == 0) begin
                    if (errors < MAX_REPORTS)
                        $display("%0t: unexpected result rgba=%h last=%b",
                                 $time, m_tdata, m_tlast);
                    errors++;
                end else begin
                    want = expected_px.pop_front();
                    if (want.rgba !== m_tdata) begin
                        if (errors < MAX_REPORTS)
                            $display("%0t: rgba expected %h actual %h",
                                     $time, want.rgba, m_tdata);
                        errors++;
                    end
                    if (want.frame_end !== m_tlast) begin
                        if (errors < MAX_REPORTS)
                            $display("%0t: frame end expected %b actual %b",
                                     $time, want.frame_end, m_tlast);
                        errors++;
                    end
                end
            end
            m_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** sprite_outline_filter_unit: FAILED **");
            $finish;
        end
    end

    // hold until every request is taken and every result has come back
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_src.size() != 0 || s_tvalid || expected_px.size() != 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk);
        while (!cfg_ready);
        case (idx)
            sof_pkg::REG_IMAGE_WIDTH:   width_reg   = data[8:0];
            sof_pkg::REG_IMAGE_HEIGHT:  height_reg  = data[12:0];
            sof_pkg::REG_OUTLINE_COLOR: outline_reg = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h,
                             input logic [31:0] color);
        logic [31:0] junk;
        wait_drained();
        junk = $urandom_range(1) ? $urandom : 32'h0;
        write_reg(sof_pkg::REG_IMAGE_WIDTH, (junk & 32'hFFFF_FE00) | w[8:0]);
        junk = $urandom_range(1) ? $urandom : 32'h0;
        write_reg(sof_pkg::REG_IMAGE_HEIGHT, (junk & 32'hFFFF_E000) | h[12:0]);
        write_reg(sof_pkg::REG_OUTLINE_COLOR, color);
    endtask

    task automatic run_random_frames(input int budget);
        int          spent;
        int unsigned w, h, pick;
        spent = 0;
        while (spent < budget) begin
            if ($urandom_range(99) < 60) begin
                pick = $urandom_range(19);
                if (pick == 0) w = 0;
                else if (pick <= 2) w = $urandom_range(13, 48);
                else w = $urandom_range(1, 12);
                h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
                set_frame(w, h, $urandom);
            end else if ($urandom_range(9) == 0) begin
                wait_drained();
            end
            spent += queue_frame($urandom_range(10, 70),
                                 ($urandom_range(99) < 15) ? 10 : 0);
        end
    endtask

    initial begin : run_stimulus
        foreach (color_line[i]) color_line[i] = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // default sizes, receiver held off while the sender keeps offering
        fork
            begin
                @(posedge aclk);
                rx_hold <= 1'b1;
                repeat (LONG_HOLD) @(posedge aclk);
                rx_hold <= 1'b0;
            end
        join_none
        void'(queue_frame(40, 0));

        set_frame(3, 3, 32'h1234_5678);
        push_item(32'h00FF_FFFF, 1'b0);
        push_item(32'hFF00_0000, 1'b0);
        push_item(32'h0000_0000, 1'b0);
        push_item(32'h0100_0000, 1'b0);
        push_item(32'hFFFF_FFFF, 1'b1);
        push_item(32'h80AB_CDEF, 1'b0);
        push_item(32'h0000_0000, 1'b0);
        push_item(32'h0000_0000, 1'b0);
        push_item(32'hFFFF_FFFF, 1'b0);
        push_item(32'h0000_0000, 1'b1);
        push_item(32'hFFFF_FFFF, 1'b0);
        push_item(32'h5A5A_5A5A, 1'b1);
        push_item(32'h0000_0000, 1'b1);

        wait_drained();
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        set_frame(0, 0, 32'h0000_0000);
        push_item(32'hFF00_0000, 1'b0);
        push_item(32'h0000_0000, 1'b1);
        push_item(32'h0000_0000, 1'b1);
        push_item(32'h007F_FFFF, 1'b0);
        push_item(32'h0000_0000, 1'b1);
        push_item(32'h0000_0000, 1'b1);

        set_frame(2, 1, 32'hFFFF_FFFF);
        push_item(32'h0000_0000, 1'b0);
        push_item(32'h01FF_FFFF, 1'b0);
        push_item(32'h0000_0000, 1'b1);
        push_item(32'h0000_0000, 1'b1);
        push_item(32'h0000_0000, 1'b1);

        wait_drained();
        send_idle_pct = 84;
        run_random_frames(PHASE_ITEMS);

        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 84;
        run_random_frames(PHASE_ITEMS);

        wait_drained();
        send_idle_pct  = 17;
        recv_stall_pct = 17;
        run_random_frames(PHASE_ITEMS);

        wait_drained();
        repeat (END_SETTLE) @(negedge aclk);
        if (errors == 0 && expected_px.size() == 0) begin
            $display("** sprite_outline_filter_unit: PASSED **");
        end else begin
            $display("** sprite_outline_filter_unit: FAILED **");
        end
        $finish;
    end

endmodule
